FILE: rtl/knapsack_best_value_unit_assert.svh
// assertion macros for the knapsack best value unit
`ifndef KNAPSACK_BEST_VALUE_UNIT_ASSERT_SVH
`define KNAPSACK_BEST_VALUE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define KBV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("kbv assertion failed");
// condition must never be seen outside reset
`define KBV_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("kbv forbidden condition seen");
`else
`define KBV_ASSERT(lbl, prop)
`define KBV_ASSERT_NEVER(lbl, cond)
`endif

`endif

FILE: rtl/kbv_pkg.sv
package kbv_pkg;

  // fixed field widths
  localparam int unsigned IN_VAL_W = 16;
  localparam int unsigned IN_WT_W  = 10;
  localparam int unsigned CFG_W    = 10;

  // sequencer states
  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_WALK  = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_RES   = 6'b010000,
    ST_CAP   = 6'b100000
  } state_e;

endpackage

FILE: rtl/kbv_mem.sv
module kbv_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 24
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [DW-1:0] rdata_a_o,
  output logic [DW-1:0] rdata_b_o
);

  logic [DW-1:0] mem_q [DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

FILE: rtl/kbv_upd.sv
module kbv_upd #(
  parameter int unsigned VALUE_BITS  = 16,
  parameter int unsigned RESULT_BITS = 24
) (
  input  logic [RESULT_BITS-1:0]       old_i,
  input  logic [RESULT_BITS-1:0]       base_i,
  input  logic [kbv_pkg::IN_VAL_W-1:0] value_i,
  output logic [RESULT_BITS-1:0]       new_o
);
  import kbv_pkg::*;

  localparam int unsigned SW = ((RESULT_BITS > VALUE_BITS) ? RESULT_BITS : VALUE_BITS) + 1;

  logic [31:0]            value_ext;
  logic [VALUE_BITS-1:0]  value_m;
  logic [SW-1:0]          sum;
  logic [SW-1:0]          limit;
  logic [RESULT_BITS-1:0] cand;

  // keep only the low value bits
  assign value_ext = 32'(value_i);
  assign value_m   = value_ext[VALUE_BITS-1:0];

  // saturating add of item value onto the shifted entry
  assign sum   = SW'(base_i) + SW'(value_m);
  assign limit = SW'({RESULT_BITS{1'b1}});
  assign cand  = (sum > limit) ? limit[RESULT_BITS-1:0] : sum[RESULT_BITS-1:0];

  // keep the better of packing or skipping
  assign new_o = (cand > old_i) ? cand : old_i;

endmodule

FILE: rtl/knapsack_best_value_unit.sv
// 0/1 knapsack best value over a row memory, one entry updated per cycle in a walk.
// item of weight w under effective capacity c: accepted, then walked from entry c
// down to entry w (one read-modify-write per cycle); items heavier than c skip the walk.
// last item adds read and capture (with a drain step first after a walk), then
// a clear pass over all MAX_CAPACITY+1 entries; result appears in the cycle after capture.
// reset: capacity 0, row cleared by a pass over all MAX_CAPACITY+1 entries, input stalled.
`include "knapsack_best_value_unit_assert.svh"

module knapsack_best_value_unit #(
  parameter int unsigned MAX_CAPACITY = 1023,
  parameter int unsigned VALUE_BITS   = 16,
  parameter int unsigned RESULT_BITS  = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [kbv_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [kbv_pkg::IN_VAL_W-1:0] item_value_i,
  input  logic [kbv_pkg::IN_WT_W-1:0]  item_weight_i,
  input  logic                         last_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [RESULT_BITS-1:0]       best_value_o
);
  import kbv_pkg::*;

  localparam int unsigned DEPTH = MAX_CAPACITY + 1;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_e state_q, state_d;
  logic [CFG_W-1:0]       cap_cfg_q;
  logic [AW-1:0]          cap_eff;
  logic [AW-1:0]          addr_q, addr_d;
  logic [AW-1:0]          cap_q, cap_d;
  logic [AW-1:0]          wt_q, wt_d;
  logic [IN_VAL_W-1:0]    val_q, val_d;
  logic                   last_q, last_d;
  logic                   pend_q;
  logic [AW-1:0]          pend_addr_q;
  logic                   out_valid_q, out_valid_d;
  logic [RESULT_BITS-1:0] best_q, best_d;
  logic                   fits;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [RESULT_BITS-1:0] mem_wdata;
  logic [AW-1:0]          mem_raddr_a;
  logic [AW-1:0]          mem_raddr_b;
  logic [RESULT_BITS-1:0] rd_a;
  logic [RESULT_BITS-1:0] rd_b;
  logic [RESULT_BITS-1:0] upd_new;

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_cfg_q <= '0;
    end else if (cfg_we_i) begin
      cap_cfg_q <= cfg_wdata_i;
    end
  end

  // clamp capacity to MAX_CAPACITY, the last row entry
  always_comb begin
    if (32'(cap_cfg_q) > 32'(MAX_CAPACITY)) begin
      cap_eff = AW'(MAX_CAPACITY);
    end else begin
      cap_eff = AW'(cap_cfg_q);
    end
  end

  assign fits       = (32'(item_weight_i) <= 32'(cap_eff));
  assign in_stall_o = (state_q != ST_IDLE);

  // row memory
  kbv_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (RESULT_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // entry update
  kbv_upd #(
    .VALUE_BITS  (VALUE_BITS),
    .RESULT_BITS (RESULT_BITS)
  ) u_upd (
    .old_i   (rd_a),
    .base_i  (rd_b),
    .value_i (val_q),
    .new_o   (upd_new)
  );

  // memory port steering
  assign mem_we      = (state_q == ST_CLEAR) || pend_q;
  assign mem_waddr   = (state_q == ST_CLEAR) ? addr_q : pend_addr_q;
  assign mem_wdata   = (state_q == ST_CLEAR) ? '0 : upd_new;
  assign mem_raddr_a = (state_q == ST_RES) ? cap_q : addr_q;
  assign mem_raddr_b = addr_q - wt_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    cap_d       = cap_q;
    wt_d        = wt_q;
    val_d       = val_q;
    last_d      = last_q;
    best_d      = best_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_CLEAR: begin
        if (addr_q == AW'(MAX_CAPACITY)) begin
          state_d = ST_IDLE;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          val_d  = item_value_i;
          wt_d   = AW'(item_weight_i);
          cap_d  = cap_eff;
          last_d = last_item_i;
          if (fits) begin
            addr_d  = cap_eff;
            state_d = ST_WALK;
          end else if (last_item_i) begin
            state_d = ST_RES;
          end
        end
      end
      ST_WALK: begin
        if (addr_q == wt_q) begin
          state_d = last_q ? ST_DRAIN : ST_IDLE;
        end else begin
          addr_d = addr_q - AW'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_RES;
      end
      ST_RES: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_CAP;
        end
      end
      ST_CAP: begin
        best_d      = rd_a;
        out_valid_d = 1'b1;
        addr_d      = '0;
        state_d     = ST_CLEAR;
      end
      default: begin
        state_d = ST_CLEAR;
        addr_d  = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      addr_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      pend_q      <= (state_q == ST_WALK);
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cap_q       <= cap_d;
    wt_q        <= wt_d;
    val_q       <= val_d;
    best_q      <= best_d;
    pend_addr_q <= addr_q;
  end

  assign out_valid_o  = out_valid_q;
  assign best_value_o = best_q;

  // checks
  `KBV_ASSERT(a_word_from_capture, $rose(out_valid_q) |-> $past(state_q) == ST_CAP)
  `KBV_ASSERT_NEVER(a_no_overwrite, (state_q == ST_CAP) && out_valid_q)
  `KBV_ASSERT(a_walk_in_range, (state_q == ST_WALK) |-> (addr_q >= wt_q) && (addr_q <= cap_q))

endmodule

FILE: tb/knapsack_value_checker.sv
module knapsack_value_checker #(
  parameter int unsigned MAX_CAPACITY = 1023,
  parameter int unsigned RESULT_BITS  = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [kbv_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [kbv_pkg::IN_VAL_W-1:0] item_value_i,
  input  logic [kbv_pkg::IN_WT_W-1:0]  item_weight_i,
  input  logic                         last_item_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [RESULT_BITS-1:0]       best_value_i,
  output int                           fail_count_o,
  output int                           pending_o
);

  typedef logic [RESULT_BITS-1:0] total_t;

  // predicted row of best totals, one per capacity
  total_t                    best_row [MAX_CAPACITY+1];
  total_t                    best_value_q [$];
  total_t                    expected_value;
  logic [kbv_pkg::CFG_W-1:0] capacity_q;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // total plus item value, pinned at the largest result
  function automatic total_t add_sat(total_t base, logic [kbv_pkg::IN_VAL_W-1:0] gain);
    logic [RESULT_BITS:0] sum;
    sum = (RESULT_BITS+1)'(base) + (RESULT_BITS+1)'(gain);
    if (sum[RESULT_BITS]) begin
      return '1;
    end
    return sum[RESULT_BITS-1:0];
  endfunction

  function automatic void clear_row();
    foreach (best_row[k]) begin
      best_row[k] = '0;
    end
  endfunction

  // walk the row top down so each item is packed at most once
  function automatic void fold_item(logic [kbv_pkg::IN_VAL_W-1:0] value,
                                    logic [kbv_pkg::IN_WT_W-1:0] weight, logic last);
    int     cap;
    int     wt;
    total_t cand;
    cap = int'(capacity_q);
    if (cap > int'(MAX_CAPACITY)) begin
      cap = int'(MAX_CAPACITY);
    end
    wt = int'(weight);
    if (wt <= cap) begin
      for (int j = cap; j >= wt; j--) begin
        cand = add_sat(best_row[j-wt], value);
        if (cand > best_row[j]) begin
          best_row[j] = cand;
        end
      end
    end
    if (last) begin
      best_value_q = {best_value_q, best_row[cap]};
      clear_row();
    end
  endfunction

  // watch both channels and the capacity port
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_row();
      capacity_q = '0;
      best_value_q.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (best_value_q.size() == 0) begin
          $display("%0t: unexpected best_value word, expected none, got %0d",
                   $time, best_value_i);
          fail_count_o++;
        end else begin
          expected_value = best_value_q.pop_front();
          if (best_value_i !== expected_value) begin
            $display("%0t: best_value mismatch, expected %0d, got %0d",
                     $time, expected_value, best_value_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        fold_item(item_value_i, item_weight_i, last_item_i);
      end
      if (cfg_we_i) begin
        capacity_q = cfg_wdata_i;
      end
      pending_o = best_value_q.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
module tb_top;

  localparam int unsigned RESULT_BITS = 24;
  localparam int          CYCLE_LIMIT = 20_000_000;
  // longest walk or clear pass of the row, with margin
  localparam int          SETTLE_CYCLES = 1200;
  localparam int          ITEM_TARGET = 550;
  localparam int          MAX_CAP = 1023;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [kbv_pkg::CFG_W-1:0]    cfg_wdata = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [kbv_pkg::IN_VAL_W-1:0] item_value = '0;
  logic [kbv_pkg::IN_WT_W-1:0]  item_weight = '0;
  logic                         last_item = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [RESULT_BITS-1:0]       best_value;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int items_sent = 0;
  int cur_cap = 0;
  int hold_count = 0;
  bit idle_on = 1'b1;

  knapsack_best_value_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .item_value_i  (item_value),
    .item_weight_i (item_weight),
    .last_item_i   (last_item),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .best_value_o  (best_value)
  );

  knapsack_value_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .item_value_i  (item_value),
    .item_weight_i (item_weight),
    .last_item_i   (last_item),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .best_value_i  (best_value),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL knapsack_best_value_unit");
      $finish;
    end
  end

  // receiver: a fresh stall count for every result word
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      hold_count = idle_on ? int'($urandom_range(0, 13)) : 0;
    end
  end

  always @(negedge clk) begin
    out_stall = (hold_count > 0);
    if (out_valid && hold_count > 0) begin
      hold_count--;
    end
  end

  task automatic drop_valid();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // one item word, after a random gap, held until taken
  task automatic send_item(input logic [kbv_pkg::IN_VAL_W-1:0] v,
                           input logic [kbv_pkg::IN_WT_W-1:0] w, input logic l);
    int gap;
    gap = idle_on ? int'($urandom_range(0, 13)) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    = 1'b1;
    item_value  = v;
    item_weight = w;
    last_item   = l;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // capacity write once the block has gone quiet
  task automatic set_capacity(input int c);
    drop_valid();
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = c[kbv_pkg::CFG_W-1:0];
    @(negedge clk);
    cfg_we  = 1'b0;
    cur_cap = c;
  endtask

  initial begin
    int n;
    int split_at;
    logic [kbv_pkg::IN_VAL_W-1:0] v;
    logic [kbv_pkg::IN_WT_W-1:0]  w;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // zero capacity: only weightless items pack
    set_capacity(0);
    send_item(16'hFFFF, 10'd0, 1'b0);
    send_item(16'd5, 10'd1, 1'b0);
    send_item(16'h1234, 10'd0, 1'b1);
    send_item(16'd0, 10'd0, 1'b1);

    // full capacity with the heaviest items
    set_capacity(MAX_CAP);
    send_item(16'hFFFF, 10'd1023, 1'b0);
    send_item(16'h8000, 10'd512, 1'b0);
    send_item(16'h7FFF, 10'd511, 1'b0);
    send_item(16'd1, 10'd0, 1'b1);

    // small textbook set, one item too heavy, one exactly at capacity
    set_capacity(10);
    send_item(16'd60, 10'd1, 1'b0);
    send_item(16'd100, 10'd2, 1'b0);
    send_item(16'd120, 10'd3, 1'b0);
    send_item(16'hFFFF, 10'd11, 1'b0);
    send_item(16'd250, 10'd10, 1'b0);
    send_item(16'd90, 10'd4, 1'b1);

    // capacity lowered part way through a set
    set_capacity(20);
    send_item(16'd50, 10'd15, 1'b0);
    send_item(16'd40, 10'd5, 1'b0);
    set_capacity(6);
    send_item(16'd30, 10'd6, 1'b0);
    send_item(16'd1, 10'd0, 1'b1);

    // lone item heavier than the capacity
    send_item(16'hFFFF, 10'd1023, 1'b1);

    // long set of heavy values to drive the total into saturation
    idle_on = ($urandom_range(0, 3) != 0);
    set_capacity($urandom_range(0, 8));
    for (int k = 0; k < 280; k++) begin
      w = ($urandom_range(0, 19) == 0) ? 10'($urandom_range(0, cur_cap)) : '0;
      send_item(16'($urandom_range(16'hF000, 16'hFFFF)), w, k == 279);
    end

    // random sets, mostly at small capacities
    while (items_sent < ITEM_TARGET) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 15))
          0:       set_capacity(0);
          1:       set_capacity(MAX_CAP);
          2, 3:    set_capacity($urandom_range(41, 300));
          default: set_capacity($urandom_range(1, 40));
        endcase
      end
      n = (cur_cap > 300) ? $urandom_range(1, 3) : $urandom_range(1, 8);
      split_at = (n > 1 && $urandom_range(0, 7) == 0) ? $urandom_range(1, n - 1) : 0;
      for (int k = 0; k < n; k++) begin
        if (split_at != 0 && k == split_at) begin
          set_capacity($urandom_range(0, 40));
        end
        case ($urandom_range(0, 7))
          0:       v = '0;
          1:       v = '1;
          2, 3:    v = 16'($urandom_range(0, 255));
          default: v = 16'($urandom_range(0, 16'hFFFF));
        endcase
        case ($urandom_range(0, 7))
          0:       w = '0;
          1:       w = 10'($urandom_range(0, MAX_CAP));
          2:       w = 10'(cur_cap);
          3:       w = (cur_cap < MAX_CAP) ? 10'(cur_cap + 1) : 10'(cur_cap);
          default: w = 10'($urandom_range(0, cur_cap));
        endcase
        send_item(v, w, k == n - 1);
      end
    end

    // drain and verdict
    drop_valid();
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS knapsack_best_value_unit");
    end else begin
      $display("FAIL knapsack_best_value_unit");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/kbv_pkg.sv
rtl/kbv_mem.sv
rtl/kbv_upd.sv
rtl/knapsack_best_value_unit.sv
tb/knapsack_value_checker.sv
tb/tb_top.sv
